### rtl/hsl_to_rgb_converter_core_assert.svh
`ifndef HSL_TO_RGB_CONVERTER_CORE_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_CORE_ASSERT_SVH

// Checked only while out of reset.
`define HSL2RGB_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define HSL2RGB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/hsl2rgb_pkg.sv
package hsl2rgb_pkg;

    localparam int HUE_W = 9;
    localparam int SAT_W = 8;
    localparam int LIT_W = 8;
    localparam int CH_W  = 8;
    localparam int CH_NUM = 3;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    localparam int PIPE_STAGES = 6;

    localparam int HX_W   = 11;
    localparam int WGT_W  = 6;
    localparam int SUM_W  = 9;
    localparam int PA_W   = 17;
    localparam int PB_W   = 16;
    localparam int LO_W   = 18;
    localparam int D_W    = 19;
    localparam int NUM_W  = 24;
    localparam int NUM_POS_W = 22;
    localparam int SCL_W  = 26;
    localparam int A_W    = 18;
    localparam int RP_W   = 35;
    localparam int Q_W    = 9;
    localparam int R_W    = 19;

    localparam int HUE_TURN      = 360;
    localparam int HUE_THIRD     = 120;
    localparam int SECT_RISE_END = 60;
    localparam int SECT_HOLD_END = 180;
    localparam int SECT_FALL_END = 240;
    localparam int WGT_FULL      = 60;
    localparam int SAT_FULL      = 200;
    localparam int LIT_HALF      = 100;
    localparam int LIT_X400      = 400;

    // 255/2400000 = 17/(256*625)
    localparam int SCALE_MUL   = 17;
    localparam int SCALE_SHIFT = 8;
    localparam int DIV_BASE    = 625;
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_M     = (1 << RECIP_SHIFT) / DIV_BASE;
    localparam int CH_MAX      = 255;
    localparam int A_CLAMP     = (CH_MAX + 1) * DIV_BASE;

    typedef logic [WGT_W-1:0]        wgt_t;
    typedef logic signed [LO_W-1:0]  lo_t;
    typedef logic signed [D_W-1:0]   diff_t;
    typedef logic signed [NUM_W-1:0] num_t;
    typedef logic [A_W-1:0]          scaled_t;
    typedef logic [Q_W-1:0]          quot_t;
    typedef logic [CH_W-1:0]         chan_t;

    // red, green, blue
    localparam logic signed [HX_W-1:0] HUE_OFS [CH_NUM] = '{
        HX_W'(HUE_THIRD), HX_W'(0), HX_W'(-HUE_THIRD)
    };

    function automatic wgt_t ramp_weight(input logic signed [HX_W-1:0] x_in);
        logic signed [HX_W-1:0] x;
        logic signed [HX_W-1:0] fall;
        wgt_t w;
        x = x_in;
        if (x < 0) begin
            x = x + HX_W'(HUE_TURN);
        end
        if (x > HX_W'(HUE_TURN)) begin
            x = x - HX_W'(HUE_TURN);
        end
        fall = HX_W'(SECT_FALL_END) - x;
        priority if (x < HX_W'(SECT_RISE_END)) begin
            w = x[WGT_W-1:0];
        end else if (x < HX_W'(SECT_HOLD_END)) begin
            w = WGT_W'(WGT_FULL);
        end else if (x < HX_W'(SECT_FALL_END)) begin
            w = fall[WGT_W-1:0];
        end else begin
            w = '0;
        end
        return w;
    endfunction

endpackage

### rtl/hsl_to_rgb_converter_core.sv
// HSL to RGB color converter. Each s_axis transaction carries one color (hue in degrees,
// saturation and lightness in half-percent steps); each m_axis transaction returns 8-bit red,
// green and blue, truncated toward zero and clamped to 0..255. The datapath is a six-stage
// pipeline (products, HSL intermediates, channel ramp, rescale, reciprocal divide, correction),
// so one transaction is accepted every clock while s_axis_tready is high; m_axis_tvalid is the
// valid bit of the correction stage. Every stage holds its own valid bit and fills empty slots
// under backpressure, so s_axis_tready stays high until all six stages hold data.
module hsl_to_rgb_converter_core
    import hsl2rgb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // hue[8:0], saturation[16:9], lightness[24:17]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // red[7:0], green[15:8], blue[23:16]
);

    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES-1:0] stg_rdy;

    logic [HUE_W-1:0] in_hue;
    logic [SAT_W-1:0] in_sat;
    logic [LIT_W-1:0] in_lit;

    // stage 0
    logic [LIT_W-1:0] lit0_reg;
    logic [SAT_W-1:0] sat0_reg;
    logic [PA_W-1:0]  pa0_reg, pa_next;
    logic [PB_W-1:0]  pb0_reg, pb_next;
    wgt_t             wgt0_reg [CH_NUM];
    wgt_t             wgt_next [CH_NUM];
    logic [SUM_W-1:0] sum_sat;

    // stage 1
    lo_t              lo1_reg, lo_next;
    diff_t            d1_reg, d_next;
    wgt_t             wgt1_reg [CH_NUM];
    logic [SUM_W-1:0] sum_ls;
    logic [PA_W-1:0]  hi_val, l400;

    // stage 2
    num_t             num2_reg [CH_NUM];
    num_t             num_next [CH_NUM];
    num_t             lo_x, lo60, d_x;

    // stage 3
    scaled_t          a3_reg [CH_NUM];
    scaled_t          a_next [CH_NUM];
    logic [SCL_W-1:0] scl_prod [CH_NUM];

    // stage 4
    scaled_t          a4_reg [CH_NUM];
    quot_t            q4_reg [CH_NUM];
    quot_t            q_next [CH_NUM];
    logic [RP_W-1:0]  rp_prod [CH_NUM];

    // stage 5
    chan_t            ch5_reg [CH_NUM];
    chan_t            ch_next [CH_NUM];
    logic [R_W-1:0]   qm [CH_NUM];
    logic [R_W-1:0]   rem [CH_NUM];
    quot_t            q_fix [CH_NUM];

    assign in_hue = s_axis_tdata[HUE_W-1:0];
    assign in_sat = s_axis_tdata[HUE_W +: SAT_W];
    assign in_lit = s_axis_tdata[HUE_W+SAT_W +: LIT_W];

    always_comb begin
        stg_rdy[PIPE_STAGES-1] = !vld_reg[PIPE_STAGES-1] || m_axis_tready;
        for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
            stg_rdy[i] = !vld_reg[i] || stg_rdy[i+1];
        end
    end

    assign s_axis_tready = stg_rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (stg_rdy[0]) begin
                vld_reg[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < PIPE_STAGES; i++) begin
                if (stg_rdy[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // stage 0: raw products and hue weights
    always_comb begin
        sum_sat = SUM_W'(SAT_FULL) + SUM_W'(in_sat);
        pa_next = PA_W'(in_lit) * PA_W'(sum_sat);
        pb_next = PB_W'(in_sat) * PB_W'(in_lit);
        for (int c = 0; c < CH_NUM; c++) begin
            wgt_next[c] = ramp_weight($signed(HX_W'(in_hue)) + HUE_OFS[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_rdy[0]) begin
            lit0_reg <= in_lit;
            sat0_reg <= in_sat;
            pa0_reg  <= pa_next;
            pb0_reg  <= pb_next;
            wgt0_reg <= wgt_next;
        end
    end

    // stage 1: hi/lo intermediates, kept as lo and hi-lo
    always_comb begin
        sum_ls = SUM_W'(lit0_reg) + SUM_W'(sat0_reg);
        l400   = PA_W'(lit0_reg) * PA_W'(LIT_X400);
        if (lit0_reg < LIT_W'(LIT_HALF)) begin
            hi_val = pa0_reg;
        end else begin
            hi_val = PA_W'(sum_ls) * PA_W'(SAT_FULL) - PA_W'(pb0_reg);
        end
        lo_next = $signed({1'b0, l400}) - $signed({1'b0, hi_val});
        d_next  = $signed({1'b0, hi_val, 1'b0}) - $signed({2'b00, l400});
    end

    always_ff @(posedge aclk) begin
        if (stg_rdy[1]) begin
            lo1_reg  <= lo_next;
            d1_reg   <= d_next;
            wgt1_reg <= wgt0_reg;
        end
    end

    // stage 2: ramp numerator lo*60 + (hi-lo)*w
    always_comb begin
        lo_x = NUM_W'(lo1_reg);
        d_x  = NUM_W'(d1_reg);
        lo60 = (lo_x <<< 6) - (lo_x <<< 2);
        for (int c = 0; c < CH_NUM; c++) begin
            num_next[c] = lo60 + d_x * $signed({1'b0, wgt1_reg[c]});
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_rdy[2]) begin
            num2_reg <= num_next;
        end
    end

    // stage 3: num*17/256, negative numerators give zero
    always_comb begin
        for (int c = 0; c < CH_NUM; c++) begin
            scl_prod[c] = SCL_W'(num2_reg[c][NUM_POS_W-1:0]) * SCL_W'(SCALE_MUL);
            if (num2_reg[c][NUM_W-1]) begin
                a_next[c] = '0;
            end else begin
                a_next[c] = scl_prod[c][SCALE_SHIFT +: A_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_rdy[3]) begin
            a3_reg <= a_next;
        end
    end

    // stage 4: reciprocal estimate of a/625, low by at most one
    always_comb begin
        for (int c = 0; c < CH_NUM; c++) begin
            rp_prod[c] = RP_W'(a3_reg[c]) * RP_W'(RECIP_M);
            q_next[c]  = rp_prod[c][RECIP_SHIFT +: Q_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_rdy[4]) begin
            a4_reg <= a3_reg;
            q4_reg <= q_next;
        end
    end

    // stage 5: correct quotient and clamp
    always_comb begin
        for (int c = 0; c < CH_NUM; c++) begin
            qm[c]    = R_W'(q4_reg[c]) * R_W'(DIV_BASE);
            rem[c]   = R_W'(a4_reg[c]) - qm[c];
            q_fix[c] = q4_reg[c] + Q_W'(rem[c] >= R_W'(DIV_BASE));
            if (a4_reg[c] >= A_W'(A_CLAMP)) begin
                ch_next[c] = CH_W'(CH_MAX);
            end else begin
                ch_next[c] = q_fix[c][CH_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_rdy[5]) begin
            ch5_reg <= ch_next;
        end
    end

    assign m_axis_tvalid = vld_reg[PIPE_STAGES-1];
    assign m_axis_tdata  = {ch5_reg[2], ch5_reg[1], ch5_reg[0]};

endmodule

### rtl/hsl2rgb_checker.sv
`include "hsl_to_rgb_converter_core_assert.svh"

module hsl2rgb_checker
    import hsl2rgb_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic in_txn;
    logic in_grey;
    logic flow_ok;
    logic out_grey;

    assign in_txn   = aresetn && s_axis_tvalid && s_axis_tready;
    assign in_grey  = in_txn && (s_axis_tdata[HUE_W +: SAT_W] == '0);
    assign flow_ok  = aresetn && m_axis_tready;
    assign out_grey = (m_axis_tdata[CH_W-1:0] == m_axis_tdata[CH_W +: CH_W]) &&
                      (m_axis_tdata[CH_W +: CH_W] == m_axis_tdata[2*CH_W +: CH_W]);

    `HSL2RGB_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_axis_tvalid, "valid after reset")

    `HSL2RGB_ASSERT(a_stall_hold, aclk, aresetn,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
        "result changed under stall")

    `HSL2RGB_ASSERT(a_latency, aclk, aresetn,
        $past(in_txn, 6) && $past(flow_ok, 1) && $past(flow_ok, 2) && $past(flow_ok, 3) &&
        $past(flow_ok, 4) && $past(flow_ok, 5) |-> m_axis_tvalid,
        "result missing six cycles after transaction")

    `HSL2RGB_ASSERT(a_grey, aclk, aresetn,
        $past(in_grey, 6) && $past(flow_ok, 1) && $past(flow_ok, 2) && $past(flow_ok, 3) &&
        $past(flow_ok, 4) && $past(flow_ok, 5) |-> out_grey,
        "zero saturation did not give grey")

endmodule

bind hsl_to_rgb_converter_core hsl2rgb_checker u_hsl2rgb_checker (.*);
